@@ rtl/lqs_pkg.sv @@
// lqs_pkg: shared types, sizes and codes of the linear array queue with search
// used by every module of the block; no dependencies
package lqs_pkg;

  localparam int unsigned Depth     = 8;
  localparam int unsigned IdxW      = $clog2(Depth);
  localparam int unsigned DataW     = 32;
  localparam int unsigned CmdQDepth = 2;
  localparam int unsigned CmdPtrW   = $clog2(CmdQDepth);

  // request mode codes
  localparam logic [2:0] MODE_ENQ  = 3'd0;
  localparam logic [2:0] MODE_DEQ  = 3'd1;
  localparam logic [2:0] MODE_PEEK = 3'd2;
  localparam logic [2:0] MODE_DISP = 3'd3;
  localparam logic [2:0] MODE_SRCH = 3'd4;

  // result status codes
  localparam logic [1:0] STS_OK       = 2'd0;
  localparam logic [1:0] STS_FULL     = 2'd1;
  localparam logic [1:0] STS_EMPTY    = 2'd2;
  localparam logic [1:0] STS_NOTFOUND = 2'd3;

  typedef enum logic [2:0] {
    OP_ENQ,
    OP_DEQ,
    OP_PEEK,
    OP_DISP,
    OP_SRCH
  } op_e;

  typedef struct packed {
    logic [2:0]        mode;
    logic signed [31:0] value;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [2:0]         slot;
    logic signed [31:0] data;
    logic               last;
  } res_t;

  // classified request as it waits for the back end
  typedef struct packed {
    op_e              op;
    logic [DataW-1:0] key;
  } cmd_t;

endpackage

@@ rtl/lqs_front.sv @@
// lqs_front: takes requests and classifies them into queue commands
// depends on lqs_pkg
module lqs_front (
  input  logic            start,
  output logic            busy,
  input  lqs_pkg::req_t   req_i,
  input  logic            cmdq_full_i,
  output logic            cmd_push_o,
  output lqs_pkg::cmd_t   cmd_o
);

  logic known;

  assign busy = cmdq_full_i;

  always_comb begin
    known     = 1'b1;
    cmd_o.key = req_i.value;
    cmd_o.op  = lqs_pkg::OP_ENQ;
    unique case (req_i.mode)
      lqs_pkg::MODE_ENQ:  cmd_o.op = lqs_pkg::OP_ENQ;
      lqs_pkg::MODE_DEQ:  cmd_o.op = lqs_pkg::OP_DEQ;
      lqs_pkg::MODE_PEEK: cmd_o.op = lqs_pkg::OP_PEEK;
      lqs_pkg::MODE_DISP: cmd_o.op = lqs_pkg::OP_DISP;
      lqs_pkg::MODE_SRCH: cmd_o.op = lqs_pkg::OP_SRCH;
      default:            known    = 1'b0;  // unused modes are dropped here
    endcase
  end

  assign cmd_push_o = start && !cmdq_full_i && known;

endmodule

@@ rtl/lqs_cmd_fifo.sv @@
// lqs_cmd_fifo: short command queue between front and back end
// depends on lqs_pkg
module lqs_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  lqs_pkg::cmd_t cmd_i,
  input  logic          pop_i,
  output lqs_pkg::cmd_t cmd_o,
  output logic          empty_o,
  output logic          full_o
);

  lqs_pkg::cmd_t                mem_q [lqs_pkg::CmdQDepth];
  logic [lqs_pkg::CmdPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [lqs_pkg::CmdPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [lqs_pkg::CmdPtrW:0]    cnt_q, cnt_d;
  logic                         do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == (lqs_pkg::CmdPtrW+1)'(lqs_pkg::CmdQDepth));
  assign cmd_o   = mem_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == lqs_pkg::CmdPtrW'(lqs_pkg::CmdQDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == lqs_pkg::CmdPtrW'(lqs_pkg::CmdQDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

@@ rtl/lqs_back.sv @@
// lqs_back: executes queue commands, holds head, tail and entries, walks for
// display and search; depends on lqs_pkg
module lqs_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  lqs_pkg::cmd_t cmd_i,
  input  logic          cmd_empty_i,
  output logic          cmd_pop_o,
  output logic          res_valid_o,
  output lqs_pkg::res_t res_o
);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_WALK  = 2'd1;
  localparam logic [1:0] S_FLUSH = 2'd2;

  logic [1:0]                state_q, state_d;
  logic                      empty_q, empty_d;
  logic [lqs_pkg::IdxW-1:0]  head_q, head_d;
  logic [lqs_pkg::IdxW-1:0]  tail_q, tail_d;
  logic [lqs_pkg::IdxW-1:0]  idx_q, idx_d;
  logic                      srch_q, srch_d;
  logic [lqs_pkg::DataW-1:0] key_q, key_d;
  logic                      pend_q, pend_d;
  logic [lqs_pkg::IdxW-1:0]  pend_slot_q, pend_slot_d;
  logic [lqs_pkg::DataW-1:0] pend_data_q, pend_data_d;
  logic                      res_valid_q, res_valid_d;
  lqs_pkg::res_t             res_q, res_d;

  logic [lqs_pkg::DataW-1:0] entries_q [lqs_pkg::Depth];
  logic                      wr_en;
  logic [lqs_pkg::IdxW-1:0]  wr_idx;
  logic                      full;
  logic [lqs_pkg::DataW-1:0] walk_data;
  logic                      hit;

  assign full      = !empty_q && (tail_q == lqs_pkg::IdxW'(lqs_pkg::Depth - 1));
  assign wr_idx    = empty_q ? '0 : tail_q + 1'b1;
  assign walk_data = entries_q[idx_q];
  assign hit       = (walk_data == key_q);

  always_comb begin
    state_d     = state_q;
    empty_d     = empty_q;
    head_d      = head_q;
    tail_d      = tail_q;
    idx_d       = idx_q;
    srch_d      = srch_q;
    key_d       = key_q;
    pend_d      = pend_q;
    pend_slot_d = pend_slot_q;
    pend_data_d = pend_data_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    cmd_pop_o   = 1'b0;
    wr_en       = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_pop_o    = 1'b1;
          res_valid_d  = 1'b1;
          res_d.status = lqs_pkg::STS_OK;
          res_d.slot   = '0;
          res_d.data   = '0;
          res_d.last   = 1'b1;
          unique case (cmd_i.op)
            lqs_pkg::OP_ENQ: begin
              if (full) begin
                res_d.status = lqs_pkg::STS_FULL;
              end else begin
                wr_en      = 1'b1;
                tail_d     = wr_idx;
                empty_d    = 1'b0;
                res_d.slot = wr_idx;
                if (empty_q) begin
                  head_d = '0;
                end
              end
            end
            lqs_pkg::OP_DEQ, lqs_pkg::OP_PEEK: begin
              if (empty_q) begin
                res_d.status = lqs_pkg::STS_EMPTY;
              end else begin
                res_d.slot = head_q;
                res_d.data = entries_q[head_q];
                if (cmd_i.op == lqs_pkg::OP_DEQ) begin
                  if (head_q == tail_q) begin
                    empty_d = 1'b1;
                  end else begin
                    head_d = head_q + 1'b1;
                  end
                end
              end
            end
            lqs_pkg::OP_DISP, lqs_pkg::OP_SRCH: begin
              if (empty_q) begin
                res_d.status = lqs_pkg::STS_EMPTY;
              end else begin
                res_valid_d = 1'b0;
                state_d     = S_WALK;
                idx_d       = head_q;
                srch_d      = (cmd_i.op == lqs_pkg::OP_SRCH);
                key_d       = cmd_i.key;
                pend_d      = 1'b0;
              end
            end
            default: begin
              res_valid_d = 1'b0;
            end
          endcase
        end
      end
      S_WALK: begin
        if (!srch_q) begin
          res_valid_d  = 1'b1;
          res_d.status = lqs_pkg::STS_OK;
          res_d.slot   = idx_q;
          res_d.data   = walk_data;
          res_d.last   = (idx_q == tail_q);
        end else if (hit) begin
          // a match is held back one step so the final one can carry last
          res_valid_d  = pend_q;
          res_d.status = lqs_pkg::STS_OK;
          res_d.slot   = pend_slot_q;
          res_d.data   = pend_data_q;
          res_d.last   = 1'b0;
          pend_d       = 1'b1;
          pend_slot_d  = idx_q;
          pend_data_d  = walk_data;
        end
        if (idx_q == tail_q) begin
          state_d = srch_q ? S_FLUSH : S_IDLE;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_FLUSH: begin
        res_valid_d = 1'b1;
        res_d.last  = 1'b1;
        if (pend_q) begin
          res_d.status = lqs_pkg::STS_OK;
          res_d.slot   = pend_slot_q;
          res_d.data   = pend_data_q;
        end else begin
          res_d.status = lqs_pkg::STS_NOTFOUND;
          res_d.slot   = '0;
          res_d.data   = '0;
        end
        pend_d  = 1'b0;
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      empty_q     <= 1'b1;
      head_q      <= '0;
      tail_q      <= '0;
      idx_q       <= '0;
      srch_q      <= 1'b0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      empty_q     <= empty_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      idx_q       <= idx_d;
      srch_q      <= srch_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q       <= key_d;
    pend_slot_q <= pend_slot_d;
    pend_data_q <= pend_data_d;
    res_q       <= res_d;
    if (wr_en) begin
      entries_q[wr_idx] <= cmd_i.key;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ rtl/linear_array_queue_with_search_unit.sv @@
// linear_array_queue_with_search_unit: top level of the array queue with search
// depends on lqs_pkg, lqs_front, lqs_cmd_fifo, lqs_back
//
// A request is taken on a rising edge with start high and busy low; modes 5 to 7 are
// dropped without a result. Requests wait in a two-entry command queue while the back
// end works, so busy rises only when that queue is full. Enqueue, dequeue and peek are
// handled by the back end straight from its idle state; display and search walk the
// array a single entry at a time from head to tail, and search ends with a flush step.
// A result shows on res_o for one cycle with res_valid_o high, once its request has passed
// through the command queue and the back-end result register; the receiver must take it
// then, since results cannot be held off. The last result of each request has last set.
module linear_array_queue_with_search_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  lqs_pkg::req_t req_i,
  output logic          res_valid_o,
  output lqs_pkg::res_t res_o
);

  lqs_pkg::cmd_t push_cmd;
  lqs_pkg::cmd_t head_cmd;
  logic          push;
  logic          pop;
  logic          q_empty;
  logic          q_full;

  lqs_front u_front (
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cmdq_full_i (q_full),
    .cmd_push_o  (push),
    .cmd_o       (push_cmd)
  );

  lqs_cmd_fifo u_cmd_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .cmd_o   (head_cmd),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  lqs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .cmd_empty_i (q_empty),
    .cmd_pop_o   (pop),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule
